@@ hdl/pft_pkg.sv @@
// shared types, character codes and sizes of the properties tokenizer
package pft_pkg;

    // pending blank buffer size and derived widths
    localparam int PENDING_DEPTH = 16;
    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    localparam int CHAR_W = 16;
    localparam int HEX_DIGITS = 4;

    // character codes
    localparam logic [CHAR_W-1:0] CH_HASH  = 16'h0023;
    localparam logic [CHAR_W-1:0] CH_BANG  = 16'h0021;
    localparam logic [CHAR_W-1:0] CH_EQ    = 16'h003D;
    localparam logic [CHAR_W-1:0] CH_COLON = 16'h003A;
    localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
    localparam logic [CHAR_W-1:0] CH_SP    = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
    localparam logic [CHAR_W-1:0] CH_BSL   = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_LO_U  = 16'h0075;
    localparam logic [CHAR_W-1:0] CH_UP_U  = 16'h0055;
    localparam logic [CHAR_W-1:0] CH_LO_T  = 16'h0074;
    localparam logic [CHAR_W-1:0] CH_LO_N  = 16'h006E;
    localparam logic [CHAR_W-1:0] CH_LO_R  = 16'h0072;
    localparam logic [CHAR_W-1:0] CH_0     = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_9     = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 16'h0066;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 16'h0041;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 16'h0046;

    // token kinds
    localparam logic [1:0] KIND_KEY_CHAR   = 2'd0;
    localparam logic [1:0] KIND_KEY_END    = 2'd1;
    localparam logic [1:0] KIND_VALUE_CHAR = 2'd2;
    localparam logic [1:0] KIND_PAIR_END   = 2'd3;

    // parse phases
    localparam logic [2:0] PH_AWAIT_KEY   = 3'd0;
    localparam logic [2:0] PH_KEY         = 3'd1;
    localparam logic [2:0] PH_AWAIT_VALUE = 3'd2;
    localparam logic [2:0] PH_VALUE       = 3'd3;
    localparam logic [2:0] PH_COMMENT     = 3'd4;

    // escape phases
    localparam logic [1:0] ESC_NONE      = 2'd0;
    localparam logic [1:0] ESC_BACKSLASH = 2'd1;
    localparam logic [1:0] ESC_UNICODE   = 2'd2;

    // result slots of one input character, in emission order
    localparam int NSLOT = 5;
    localparam int SLOT_W = 3;
    localparam logic [SLOT_W-1:0] SLOT_PRE_HEX  = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_FLUSH    = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_MAIN     = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_TAIL_HEX = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_PAIR     = 3'd4;

    // emission plan of one character
    typedef struct packed {
        logic              pre_hex;
        logic [CNT_W-1:0]  flush_n;
        logic [1:0]        flush_kind;
        logic              main_en;
        logic [1:0]        main_kind;
        logic [CHAR_W-1:0] main_char;
        logic              tail_hex;
        logic              tail_pair;
        logic              ov;
        logic [CHAR_W-1:0] hex_val;
    } t_plan;

    typedef struct packed {
        logic              load;
        logic              emit;
        logic [SLOT_W-1:0] sel;
        logic [IDX_W-1:0]  fidx;
        logic              last;
    } t_dp_cmd;

    typedef struct packed {
        logic              pre_hex;
        logic [CNT_W-1:0]  flush_n;
        logic              main_en;
        logic              tail_hex;
        logic              tail_pair;
        logic              out_free;
    } t_dp_status;

endpackage

@@ hdl/pft_if.sv @@
// valid/ready channel interfaces for character words and token words
interface pft_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic        end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface pft_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  token_kind;
    logic [15:0] out_char;
    logic        blank_overflow;
    logic        last_of_run;

    modport source (output valid, output token_kind, output out_char,
                    output blank_overflow, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input out_char,
                  input blank_overflow, input last_of_run, output ready);
endinterface

@@ hdl/pft_datapath.sv @@
// tokenizer datapath: parse state, blank buffer, emission plan and output register
module pft_datapath
    import pft_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_end_of_text,
    input  logic              i_out_ready,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_st,
    output logic              o_out_valid,
    output logic [1:0]        o_token_kind,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_blank_overflow,
    output logic              o_last_of_run
);

    logic [2:0]         r_phase, n_phase;
    logic [1:0]         r_esc, n_esc;
    logic [CHAR_W-1:0]  r_hex, n_hex;
    logic [2:0]         r_hcnt, n_hcnt;
    logic               r_cont, n_cont;
    logic               r_skip, n_skip;
    logic [CNT_W-1:0]   r_pcnt, n_pcnt;
    logic               r_ovf, n_ovf;
    logic [PENDING_DEPTH-1:0] r_blank;
    t_plan              r_plan, n_plan;

    logic               r_out_valid;
    logic [1:0]         r_kind;
    logic [CHAR_W-1:0]  r_char;
    logic               r_ov;
    logic               r_last;

    logic [CHAR_W-1:0]  c;
    logic               blank, white, brk;
    logic               ovf_set, clr_ov, do_valchar, do_plain;
    logic               wr_en, wr_tab;
    logic [IDX_W-1:0]   wr_idx;
    logic               hex_ok;
    logic [3:0]         hex_d;
    logic [CHAR_W-1:0]  esc_v;
    logic [1:0]         e_kind;
    logic [CHAR_W-1:0]  e_char;

    assign c     = i_char_code;
    assign blank = (c == CH_SP) || (c == CH_TAB);
    assign brk   = (c == CH_CR) || (c == CH_LF);
    assign white = blank || brk;

    // hex digit decode
    always_comb begin
        hex_ok = 1'b0;
        hex_d  = c[3:0];
        if (c >= CH_0 && c <= CH_9) begin
            hex_ok = 1'b1;
        end else if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
            hex_ok = 1'b1;
            hex_d  = c[3:0] + 4'd9;
        end
    end

    // single character escapes
    always_comb begin
        esc_v = c;
        if (c == CH_LO_T) begin
            esc_v = CH_TAB;
        end else if (c == CH_LO_N) begin
            esc_v = CH_LF;
        end else if (c == CH_LO_R) begin
            esc_v = CH_CR;
        end
    end

    // next state and emission plan of the incoming character
    always_comb begin
        n_phase    = r_phase;
        n_esc      = r_esc;
        n_hex      = r_hex;
        n_hcnt     = r_hcnt;
        n_cont     = r_cont;
        n_skip     = r_skip;
        n_pcnt     = r_pcnt;
        n_ovf      = r_ovf;
        n_plan     = '0;
        ovf_set    = 1'b0;
        clr_ov     = 1'b0;
        do_valchar = 1'b0;
        do_plain   = 1'b0;
        wr_en      = 1'b0;
        wr_tab     = (c == CH_TAB);
        wr_idx     = r_pcnt[IDX_W-1:0];

        case (r_phase)
            PH_AWAIT_KEY: begin
                if (c == CH_HASH || c == CH_BANG) begin
                    n_phase = PH_COMMENT;
                end else if (!white) begin
                    n_phase = PH_KEY;
                    n_pcnt  = '0;
                    n_plan.main_en   = 1'b1;
                    n_plan.main_kind = KIND_KEY_CHAR;
                    n_plan.main_char = c;
                end
            end
            PH_KEY: begin
                if (c == CH_EQ || c == CH_COLON) begin
                    n_pcnt  = '0;
                    n_plan.main_en   = 1'b1;
                    n_plan.main_kind = KIND_KEY_END;
                    clr_ov  = 1'b1;
                    n_phase = PH_AWAIT_VALUE;
                end else if (blank) begin
                    if (n_pcnt < CNT_W'(PENDING_DEPTH)) begin
                        wr_en  = 1'b1;
                        wr_idx = n_pcnt[IDX_W-1:0];
                        n_pcnt = n_pcnt + CNT_W'(1);
                    end else begin
                        ovf_set = 1'b1;
                    end
                end else begin
                    n_plan.flush_n    = n_pcnt;
                    n_plan.flush_kind = KIND_KEY_CHAR;
                    n_pcnt = '0;
                    n_plan.main_en   = 1'b1;
                    n_plan.main_kind = KIND_KEY_CHAR;
                    n_plan.main_char = c;
                end
            end
            PH_AWAIT_VALUE: begin
                if (brk) begin
                    n_pcnt  = '0;
                    n_plan.main_en   = 1'b1;
                    n_plan.main_kind = KIND_PAIR_END;
                    clr_ov  = 1'b1;
                    n_phase = PH_AWAIT_KEY;
                    n_esc   = ESC_NONE;
                    n_cont  = 1'b0;
                    n_skip  = 1'b0;
                end else if (!blank) begin
                    n_phase    = PH_VALUE;
                    n_esc      = ESC_NONE;
                    n_pcnt     = '0;
                    n_cont     = 1'b0;
                    n_skip     = 1'b0;
                    do_valchar = 1'b1;
                end
            end
            PH_VALUE: begin
                do_valchar = 1'b1;
            end
            default: begin
                if (brk) begin
                    n_phase = PH_AWAIT_KEY;
                end
            end
        endcase

        // value character, escape handling
        if (do_valchar) begin
            if (n_esc == ESC_BACKSLASH) begin
                n_esc = ESC_NONE;
                if (brk) begin
                    n_cont = 1'b1;
                    n_skip = (c == CH_CR);
                end else if (c == CH_LO_U || c == CH_UP_U) begin
                    n_plan.flush_n    = n_pcnt;
                    n_plan.flush_kind = KIND_VALUE_CHAR;
                    n_pcnt = '0;
                    n_esc  = ESC_UNICODE;
                    n_hex  = '0;
                    n_hcnt = '0;
                end else begin
                    n_plan.flush_n    = n_pcnt;
                    n_plan.flush_kind = KIND_VALUE_CHAR;
                    n_pcnt = '0;
                    n_plan.main_en   = 1'b1;
                    n_plan.main_kind = KIND_VALUE_CHAR;
                    n_plan.main_char = esc_v;
                end
            end else if (n_esc == ESC_UNICODE) begin
                if (hex_ok) begin
                    n_hex  = {n_hex[CHAR_W-5:0], hex_d};
                    n_hcnt = n_hcnt + 3'd1;
                    if (n_hcnt == 3'(HEX_DIGITS)) begin
                        n_plan.main_en   = 1'b1;
                        n_plan.main_kind = KIND_VALUE_CHAR;
                        n_plan.main_char = n_hex;
                        n_esc = ESC_NONE;
                    end
                end else begin
                    // non-hex ends the escape early, char is reprocessed
                    n_plan.pre_hex = 1'b1;
                    n_esc    = ESC_NONE;
                    do_plain = 1'b1;
                end
            end else begin
                do_plain = 1'b1;
            end
        end

        // plain value character
        if (do_plain) begin
            if (c == CH_BSL) begin
                n_cont = 1'b0;
                n_esc  = ESC_BACKSLASH;
            end else if (c == CH_LF && n_cont && n_skip) begin
                n_skip = 1'b0;
            end else if (brk) begin
                n_pcnt  = '0;
                n_plan.main_en   = 1'b1;
                n_plan.main_kind = KIND_PAIR_END;
                clr_ov  = 1'b1;
                n_phase = PH_AWAIT_KEY;
                n_esc   = ESC_NONE;
                n_cont  = 1'b0;
                n_skip  = 1'b0;
            end else if (n_cont && blank) begin
                n_skip = 1'b0;
            end else begin
                n_cont = 1'b0;
                if (blank) begin
                    if (n_pcnt < CNT_W'(PENDING_DEPTH)) begin
                        wr_en  = 1'b1;
                        wr_idx = n_pcnt[IDX_W-1:0];
                        n_pcnt = n_pcnt + CNT_W'(1);
                    end else begin
                        ovf_set = 1'b1;
                    end
                end else begin
                    n_plan.flush_n    = n_pcnt;
                    n_plan.flush_kind = KIND_VALUE_CHAR;
                    n_pcnt = '0;
                    n_plan.main_en   = 1'b1;
                    n_plan.main_kind = KIND_VALUE_CHAR;
                    n_plan.main_char = c;
                end
            end
        end

        // all results of one character share one overflow flag
        n_plan.ov      = r_ovf | ovf_set;
        n_ovf          = clr_ov ? 1'b0 : (r_ovf | ovf_set);
        n_plan.hex_val = n_plan.pre_hex ? r_hex : n_hex;

        // end of text: close an open value, then back to reset state
        if (i_end_of_text) begin
            if (n_phase == PH_VALUE) begin
                n_plan.tail_hex  = (n_esc == ESC_UNICODE);
                n_plan.tail_pair = 1'b1;
            end
            n_phase = PH_AWAIT_KEY;
            n_esc   = ESC_NONE;
            n_hex   = '0;
            n_hcnt  = '0;
            n_cont  = 1'b0;
            n_skip  = 1'b0;
            n_pcnt  = '0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_AWAIT_KEY;
            r_esc   <= ESC_NONE;
            r_hex   <= '0;
            r_hcnt  <= '0;
            r_cont  <= 1'b0;
            r_skip  <= 1'b0;
            r_pcnt  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_hex   <= n_hex;
            r_hcnt  <= n_hcnt;
            r_cont  <= n_cont;
            r_skip  <= n_skip;
            r_pcnt  <= n_pcnt;
            r_ovf   <= n_ovf;
        end
    end

    // blank buffer and plan: payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_plan <= n_plan;
            if (wr_en) begin
                r_blank[wr_idx] <= wr_tab;
            end
        end
    end

    // word selection by slot
    always_comb begin
        e_kind = KIND_VALUE_CHAR;
        e_char = r_plan.hex_val;
        case (i_cmd.sel)
            SLOT_FLUSH: begin
                e_kind = r_plan.flush_kind;
                e_char = r_blank[i_cmd.fidx] ? CH_TAB : CH_SP;
            end
            SLOT_MAIN: begin
                e_kind = r_plan.main_kind;
                e_char = r_plan.main_char;
            end
            SLOT_PAIR: begin
                e_kind = KIND_PAIR_END;
                e_char = '0;
            end
            default: begin
                e_kind = KIND_VALUE_CHAR;
                e_char = r_plan.hex_val;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind <= e_kind;
            r_char <= e_char;
            r_ov   <= r_plan.ov;
            r_last <= i_cmd.last;
        end
    end

    assign o_st.pre_hex   = r_plan.pre_hex;
    assign o_st.flush_n   = r_plan.flush_n;
    assign o_st.main_en   = r_plan.main_en;
    assign o_st.tail_hex  = r_plan.tail_hex;
    assign o_st.tail_pair = r_plan.tail_pair;
    assign o_st.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_token_kind     = r_kind;
    assign o_out_char       = r_char;
    assign o_blank_overflow = r_ov;
    assign o_last_of_run    = r_last;

endmodule

@@ hdl/pft_ctrl.sv @@
// tokenizer controller: accepts a character and walks its result slots
module pft_ctrl
    import pft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              r_state, n_state;
    logic              r_fresh, n_fresh;
    logic [NSLOT-1:0]  r_todo, n_todo;
    logic [CNT_W-1:0]  r_fidx, n_fidx;

    logic [NSLOT-1:0]  mask, remaining;
    logic [SLOT_W-1:0] sel;
    logic              flush_more;

    // slots still owed; first cycle of a run takes them from the fresh plan
    assign mask = r_fresh ? {i_st.tail_pair, i_st.tail_hex, i_st.main_en,
                             (i_st.flush_n != '0), i_st.pre_hex}
                          : r_todo;

    // lowest pending slot goes first
    always_comb begin
        sel = SLOT_PRE_HEX;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (mask[i]) begin
                sel = SLOT_W'(i);
            end
        end
    end

    assign flush_more = (r_fidx + CNT_W'(1)) < i_st.flush_n;

    always_comb begin
        remaining = mask & ~(NSLOT'(1) << sel);
        if (sel == SLOT_FLUSH && flush_more) begin
            remaining = mask;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_fresh = r_fresh;
        n_todo  = r_todo;
        n_fidx  = r_fidx;
        o_cmd   = '0;
        o_cmd.sel  = sel;
        o_cmd.fidx = r_fidx[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_RUN;
                    n_fresh = 1'b1;
                    n_fidx  = '0;
                end
            end
            ST_RUN: begin
                n_fresh = 1'b0;
                if (mask == '0) begin
                    n_state = ST_IDLE;
                end else if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = (remaining == '0);
                    n_todo = remaining;
                    if (sel == SLOT_FLUSH) begin
                        n_fidx = r_fidx + CNT_W'(1);
                    end
                    if (remaining == '0) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_todo = mask;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fresh <= 1'b0;
            r_todo  <= '0;
            r_fidx  <= '0;
        end else begin
            r_state <= n_state;
            r_fresh <= n_fresh;
            r_todo  <= n_todo;
            r_fidx  <= n_fidx;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_st.out_free)
        else $error("word emitted while output register busy");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !o_cmd.emit)
        else $error("word emitted while idle");

    a_flush_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.sel == SLOT_FLUSH) |-> (r_fidx < i_st.flush_n))
        else $error("blank flush past pending count");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == ST_IDLE))
        else $error("controller busy after last word of a run");

endmodule

@@ hdl/properties_file_tokenizer_unit.sv @@
// top level of the properties text tokenizer
// Takes one UTF-16 code unit per input word and returns tagged tokens: key
// characters, key end, value characters and pair end, with comment lines and
// leading blanks skipped, value escapes (\t \n \r \\, \u with up to four hex
// digits, backslash-newline continuation) decoded and trailing spaces/tabs of
// keys and values dropped. Trailing blanks wait in a 16-entry pending buffer;
// once it is full further blanks are dropped and blank_overflow is raised on
// results until the next key end or pair end. last_of_run marks the final
// result word caused by one character. The controller handles one
// character at a time; R, the number of result words it causes (0 to 18),
// is set by how many held blanks are flushed, one per cycle while the
// output register is free, from the pending buffer. The output register
// lets the next character be taken while the final result word still
// waits. end_of_text on a character closes an open value and returns the
// parser to its reset state.
module properties_file_tokenizer_unit
    import pft_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    pft_in_if.sink   i_in,
    pft_out_if.source o_out
);

    t_dp_cmd    cmd;
    t_dp_status st;
    logic       in_ready;

    // sequencing of result slots
    pft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // parse state, pending blanks and output word register
    pft_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_char_code      (i_in.char_code),
        .i_end_of_text    (i_in.end_of_text),
        .i_out_ready      (o_out.ready),
        .i_cmd            (cmd),
        .o_st             (st),
        .o_out_valid      (o_out.valid),
        .o_token_kind     (o_out.token_kind),
        .o_out_char       (o_out.out_char),
        .o_blank_overflow (o_out.blank_overflow),
        .o_last_of_run    (o_out.last_of_run)
    );

    // input word accepted only while controller idle
    assign i_in.ready = in_ready;

endmodule

@@ dv/properties_file_tokenizer_unit_tb.sv @@
// self-checking testbench of the properties text tokenizer: character words in, token words out
module properties_file_tokenizer_unit_tb;
    import pft_pkg::*;

    localparam int ITEM_TARGET    = 270;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_LOG_LINES  = 60;

    // one character word queued for the driver
    typedef struct packed {
        logic [15:0] code;
        logic        eot;
        logic        hold_rx;     // receiver holds off once this word is taken
        logic        wait_empty;  // sender waits for all tokens before offering it
    } char_item_t;

    // one token word as the block should return it
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] ch;
        logic        ov;
        logic        last;
    } token_t;

    logic i_clk;
    logic i_rst_n;

    pft_in_if  in_if ();
    pft_out_if out_if ();

    properties_file_tokenizer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // stimulus and expectations
    char_item_t text_q[$];
    token_t     token_q[$];
    token_t     step_words[$];

    string hex_set = "0123456789abcdefABCDEF";

    // tokenizer state as predicted
    logic [2:0]  phase;
    logic [1:0]  esc_state;
    logic [15:0] hex_acc;
    logic [2:0]  hex_cnt;
    logic        cont_line;
    logic        skip_lf;
    logic        held_tab [PENDING_DEPTH];
    int          held_cnt;
    logic        blanks_lost;

    // handshake bookkeeping
    logic        in_taken;
    logic        hold_req;
    bit          cur_hold;
    int          send_gap;
    int          stall_left;
    int          hold_left;
    int          idle_cycles;
    logic [31:0] cycle_cnt;
    logic        quiet;

    // generator and scoreboard counters
    int  chars_planned;
    bit  pause_next;
    bit  hold_armed;
    bit  pause_armed;
    int  err_cnt;
    int  chars_sent;
    int  words_checked;
    int  ov_words;
    int  eot_seen;

    // a quarter of the time neither side idles
    assign quiet = (cycle_cnt[9:8] == 2'b11);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic bit is_blank(input logic [15:0] c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

    // queue one token word, tagged with the overflow flag as it stands now
    function automatic void put_word(input logic [1:0] kind, input logic [15:0] ch);
        token_t w;
        w.kind = kind;
        w.ch   = ch;
        w.ov   = blanks_lost;
        w.last = 1'b0;
        step_words.push_back(w);
    endfunction

    // trailing blank candidate; once the buffer is full it is lost and flagged
    function automatic void hold_blank(input logic [15:0] c);
        if (held_cnt < PENDING_DEPTH) begin
            held_tab[held_cnt] = (c == CH_TAB);
            held_cnt++;
        end else begin
            blanks_lost = 1'b1;
        end
    endfunction

    // held blanks turned out not to be trailing: emit them in order
    function automatic void release_blanks(input logic [1:0] kind);
        for (int i = 0; i < held_cnt; i++)
            put_word(kind, held_tab[i] ? CH_TAB : CH_SP);
        held_cnt = 0;
    endfunction

    // pair end drops held blanks and clears the overflow flag after the word
    function automatic void close_value();
        held_cnt = 0;
        put_word(KIND_PAIR_END, 16'h0000);
        blanks_lost = 1'b0;
        phase       = PH_AWAIT_KEY;
        esc_state   = ESC_NONE;
        cont_line   = 1'b0;
        skip_lf     = 1'b0;
    endfunction

    function automatic void reset_parser();
        phase       = PH_AWAIT_KEY;
        esc_state   = ESC_NONE;
        hex_acc     = '0;
        hex_cnt     = '0;
        cont_line   = 1'b0;
        skip_lf     = 1'b0;
        held_cnt    = 0;
        blanks_lost = 1'b0;
        for (int i = 0; i < PENDING_DEPTH; i++)
            held_tab[i] = 1'b0;
    endfunction

    // value character outside any escape
    function automatic void plain_value_char(input logic [15:0] c);
        if (c == CH_BSL) begin
            cont_line = 1'b0;
            esc_state = ESC_BACKSLASH;
        end else if (c == CH_LF && cont_line && skip_lf) begin
            // lf of a cr-lf continuation
            skip_lf = 1'b0;
        end else if (c == CH_LF || c == CH_CR) begin
            close_value();
        end else if (cont_line && is_blank(c)) begin
            // leading blanks of a continued line
            skip_lf = 1'b0;
        end else begin
            cont_line = 1'b0;
            if (is_blank(c)) begin
                hold_blank(c);
            end else begin
                release_blanks(KIND_VALUE_CHAR);
                put_word(KIND_VALUE_CHAR, c);
            end
        end
    endfunction

    function automatic void decode_value_char(input logic [15:0] c);
        logic [15:0] v;
        logic [3:0]  digit;
        bit          hex_ok;
        if (esc_state == ESC_BACKSLASH) begin
            esc_state = ESC_NONE;
            if (c == CH_CR || c == CH_LF) begin
                cont_line = 1'b1;
                skip_lf   = (c == CH_CR);
            end else if (c == CH_LO_U || c == CH_UP_U) begin
                // blanks before a unicode escape are kept
                release_blanks(KIND_VALUE_CHAR);
                esc_state = ESC_UNICODE;
                hex_acc   = '0;
                hex_cnt   = '0;
            end else begin
                v = c;
                if (c == CH_LO_T)
                    v = CH_TAB;
                else if (c == CH_LO_N)
                    v = CH_LF;
                else if (c == CH_LO_R)
                    v = CH_CR;
                release_blanks(KIND_VALUE_CHAR);
                put_word(KIND_VALUE_CHAR, v);
            end
        end else if (esc_state == ESC_UNICODE) begin
            hex_ok = 1'b1;
            digit  = '0;
            if (c >= CH_0 && c <= CH_9)
                digit = 4'(c - CH_0);
            else if (c >= CH_LO_A && c <= CH_LO_F)
                digit = 4'(c - CH_LO_A + 10);
            else if (c >= CH_UP_A && c <= CH_UP_F)
                digit = 4'(c - CH_UP_A + 10);
            else
                hex_ok = 1'b0;
            if (!hex_ok) begin
                // short escape: emit what was gathered, then handle c as usual
                put_word(KIND_VALUE_CHAR, hex_acc);
                esc_state = ESC_NONE;
                plain_value_char(c);
            end else begin
                hex_acc = {hex_acc[11:0], digit};
                hex_cnt = hex_cnt + 3'd1;
                if (hex_cnt >= HEX_DIGITS) begin
                    put_word(KIND_VALUE_CHAR, hex_acc);
                    esc_state = ESC_NONE;
                end
            end
        end else begin
            plain_value_char(c);
        end
    endfunction

    // tokens caused by one accepted character word, appended to token_q
    function automatic void tokenize_char(input logic [15:0] c, input logic eot);
        bit blank;
        bit white;
        blank = is_blank(c);
        white = blank || c == CH_CR || c == CH_LF;
        step_words.delete();
        case (phase)
            PH_AWAIT_KEY: begin
                if (c == CH_HASH || c == CH_BANG) begin
                    phase = PH_COMMENT;
                end else if (!white) begin
                    // '=' or ':' here is the first key character
                    phase    = PH_KEY;
                    held_cnt = 0;
                    put_word(KIND_KEY_CHAR, c);
                end
            end
            PH_KEY: begin
                if (c == CH_EQ || c == CH_COLON) begin
                    held_cnt = 0;
                    put_word(KIND_KEY_END, 16'h0000);
                    blanks_lost = 1'b0;
                    phase       = PH_AWAIT_VALUE;
                end else if (blank) begin
                    hold_blank(c);
                end else begin
                    // line breaks land here too: they are key characters
                    release_blanks(KIND_KEY_CHAR);
                    put_word(KIND_KEY_CHAR, c);
                end
            end
            PH_AWAIT_VALUE: begin
                if (c == CH_CR || c == CH_LF) begin
                    close_value();
                end else if (!blank) begin
                    phase     = PH_VALUE;
                    esc_state = ESC_NONE;
                    held_cnt  = 0;
                    cont_line = 1'b0;
                    skip_lf   = 1'b0;
                    decode_value_char(c);
                end
            end
            PH_VALUE: begin
                decode_value_char(c);
            end
            default: begin
                if (c == CH_CR || c == CH_LF)
                    phase = PH_AWAIT_KEY;
            end
        endcase
        if (eot) begin
            // an open value is finished, a pending unicode escape emitted first
            if (phase == PH_VALUE) begin
                if (esc_state == ESC_UNICODE)
                    put_word(KIND_VALUE_CHAR, hex_acc);
                close_value();
            end
            reset_parser();
        end
        if (step_words.size() > 0)
            step_words[$].last = 1'b1;
        foreach (step_words[i])
            token_q.push_back(step_words[i]);
    endfunction

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------

    task automatic add_char(input logic [15:0] code, input bit counted);
        char_item_t it;
        it.code       = code;
        it.eot        = 1'b0;
        it.hold_rx    = 1'b0;
        it.wait_empty = pause_next;
        pause_next    = 1'b0;
        text_q.push_back(it);
        if (counted)
            chars_planned++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char({8'h00, s[i]}, 1'b1);
    endtask

    task automatic add_blank_run(input int n, input bit counted);
        repeat (n)
            add_char($urandom_range(0, 1) ? CH_TAB : CH_SP, counted);
    endtask

    // mostly no blanks, sometimes enough to overrun the pending buffer
    function automatic int blank_run_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 94)
            return $urandom_range(4, 10);
        return $urandom_range(PENDING_DEPTH - 1, PENDING_DEPTH + 4);
    endfunction

    function automatic logic [15:0] text_code();
        if ($urandom_range(0, 99) < 80)
            return 16'($urandom_range(16'h21, 16'h7E));
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [15:0] hex_code();
        return {8'h00, hex_set[$urandom_range(0, 21)]};
    endfunction

    function automatic logic [15:0] line_break();
        return $urandom_range(0, 1) ? CH_LF : CH_CR;
    endfunction

    // now and then the text ends in the middle of a construct
    function automatic bit cut_text();
        if (text_q.size() > 0 && $urandom_range(0, 99) < 3) begin
            text_q[$].eot = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic add_comment_line();
        add_blank_run($urandom_range(0, 2), 1'b0);
        add_char($urandom_range(0, 1) ? CH_HASH : CH_BANG, 1'b0);
        repeat ($urandom_range(0, 5))
            add_char(text_code(), 1'b0);
        add_char(line_break(), 1'b0);
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 6))
            add_char(16'($urandom_range(0, 16'hFFFF)), 1'b1);
        if ($urandom_range(0, 4) == 0)
            text_q[$].eot = 1'b1;
    endtask

    // key, separator and value with random blanks, escapes and continuations
    task automatic add_pair();
        int nseg;
        int sel;
        int ndig;
        add_blank_run($urandom_range(0, 2), 1'b0);
        if ($urandom_range(0, 9) == 0)
            add_char($urandom_range(0, 1) ? CH_EQ : CH_COLON, 1'b1);
        else
            add_char(text_code(), 1'b1);
        nseg = $urandom_range(0, 4);
        repeat (nseg) begin
            add_blank_run(blank_run_len(), 1'b1);
            if ($urandom_range(0, 9) == 0)
                add_char(line_break(), 1'b1);
            else
                add_char(text_code(), 1'b1);
        end
        add_blank_run(blank_run_len(), 1'b1);
        if (cut_text())
            return;
        add_char($urandom_range(0, 1) ? CH_EQ : CH_COLON, 1'b1);
        if (cut_text())
            return;
        add_blank_run($urandom_range(0, 2), 1'b0);
        nseg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        repeat (nseg) begin
            add_blank_run(blank_run_len(), 1'b1);
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
                add_char(text_code(), 1'b1);
            end else if (sel < 6) begin
                add_char(CH_BSL, 1'b1);
                if (cut_text())
                    return;
                case ($urandom_range(0, 4))
                    0:       add_char(CH_LO_T, 1'b1);
                    1:       add_char(CH_LO_N, 1'b1);
                    2:       add_char(CH_LO_R, 1'b1);
                    3:       add_char(CH_BSL, 1'b1);
                    default: add_char(text_code(), 1'b1);
                endcase
            end else if (sel < 8) begin
                add_char(CH_BSL, 1'b1);
                add_char($urandom_range(0, 1) ? CH_LO_U : CH_UP_U, 1'b1);
                ndig = $urandom_range(0, HEX_DIGITS);
                repeat (ndig)
                    add_char(hex_code(), 1'b1);
                if (cut_text())
                    return;
                if (ndig < HEX_DIGITS && $urandom_range(0, 9) < 6)
                    add_char(text_code(), 1'b1);
            end else begin
                add_char(CH_BSL, 1'b1);
                if (cut_text())
                    return;
                case ($urandom_range(0, 2))
                    0: begin
                        add_char(CH_CR, 1'b1);
                        add_char(CH_LF, 1'b1);
                    end
                    1:       add_char(CH_CR, 1'b1);
                    default: add_char(CH_LF, 1'b1);
                endcase
                if (cut_text())
                    return;
                add_blank_run($urandom_range(0, 3), 1'b1);
            end
        end
        add_blank_run(blank_run_len(), 1'b1);
        if ($urandom_range(0, 9) == 0)
            text_q[$].eot = 1'b1;
        else
            add_char(line_break(), 1'b1);
    endtask

    task automatic log_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_LOG_LINES)
            $display("mismatch at word %0d: %s", words_checked, msg);
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // driver: offers character words at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        char_item_t nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            // previous word is gone (or none was offered), decide the next one
            if (send_gap > 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (text_q.size() > 0 && !(text_q[0].wait_empty && token_q.size() > 0)) begin
                nxt = text_q.pop_front();
                in_if.valid       <= 1'b1;
                in_if.char_code   <= nxt.code;
                in_if.end_of_text <= nxt.eot;
                cur_hold = nxt.hold_rx;
                send_gap = pick_gap();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus the long hold-off when requested
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 20)
                stall_left = pick_gap();
        end
    end

    // long receiver hold-off, counted here so the sender keeps pushing into a full block
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // monitor: predicts on every taken character word, checks every token word
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        token_t got;
        token_t want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
            hold_req <= 1'b0;
        end else begin
            in_taken <= in_if.valid && in_if.ready;
            hold_req <= in_if.valid && in_if.ready && cur_hold;
            if (in_if.valid && in_if.ready) begin
                tokenize_char(in_if.char_code, in_if.end_of_text);
                chars_sent++;
                if (in_if.end_of_text)
                    eot_seen++;
            end
            if (out_if.valid && out_if.ready) begin
                got.kind = out_if.token_kind;
                got.ch   = out_if.out_char;
                got.ov   = out_if.blank_overflow;
                got.last = out_if.last_of_run;
                if (token_q.size() == 0) begin
                    log_mismatch($sformatf("unexpected word kind %0d char %h ov %b last %b",
                                           got.kind, got.ch, got.ov, got.last));
                end else begin
                    want = token_q.pop_front();
                    if (got.kind !== want.kind)
                        log_mismatch($sformatf("token_kind %0d, expected %0d",
                                               got.kind, want.kind));
                    if (got.ch !== want.ch)
                        log_mismatch($sformatf("out_char %h, expected %h", got.ch, want.ch));
                    if (got.ov !== want.ov)
                        log_mismatch($sformatf("blank_overflow %b, expected %b",
                                               got.ov, want.ov));
                    if (got.last !== want.last)
                        log_mismatch($sformatf("last_of_run %b, expected %b",
                                               got.last, want.last));
                    if (want.ov)
                        ov_words++;
                end
                words_checked++;
            end
        end
    end

    // watchdog: ends the run when no word moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycle_cnt   <= '0;
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles, %0d tokens outstanding",
                     idle_cycles, token_q.size());
            $display("Some tests failed");
            $finish;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int r;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.char_code   = '0;
        in_if.end_of_text = 1'b0;
        out_if.ready      = 1'b0;
        cur_hold          = 1'b0;
        send_gap          = 0;
        stall_left        = 0;
        pause_next        = 1'b0;
        hold_armed        = 1'b0;
        pause_armed       = 1'b0;
        chars_planned     = 0;
        err_cnt           = 0;
        chars_sent        = 0;
        words_checked     = 0;
        ov_words          = 0;
        eot_seen          = 0;
        reset_parser();

        // directed: key opening with '=', line break and null inside the key,
        // blanks inside the key kept
        add_text("=\n");
        add_char(16'h0000, 1'b1);
        add_text(" \tx:");
        // value: blank kept by a unicode escape, full four-digit escape,
        // escape cut short by a non-hex digit, cr-lf continuation with the lf
        // swallowed, top code unit, and a unicode escape open at end of text
        add_text(" a\t\\u0Af9\\u9g\\\015\ny");
        add_char(16'hFFFF, 1'b1);
        add_text("\\u1");
        text_q[$].eot = 1'b1;

        // random text: mostly well-formed pairs, some comments and noise
        while (chars_planned < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                add_comment_line();
            else if (r < 90)
                add_pair();
            else
                add_noise();
            if (!hold_armed && chars_planned >= ITEM_TARGET / 3) begin
                text_q[$].hold_rx = 1'b1;
                hold_armed = 1'b1;
            end
            if (!pause_armed && chars_planned >= (2 * ITEM_TARGET) / 3) begin
                pause_next  = 1'b1;
                pause_armed = 1'b1;
            end
        end
        // close whatever is still open
        add_char(CH_LF, 1'b1);
        text_q[$].eot = 1'b1;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (text_q.size() != 0 || in_if.valid || token_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d character words sent (%0d end-of-text marks), %0d token words checked",
                 chars_sent, eot_seen, words_checked);
        $display("%0d words carried blank overflow; one %0d-cycle receiver hold-off, %s",
                 ov_words, HOLD_CYCLES, "one drain pause");
        if (err_cnt == 0 && token_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/pft_pkg.sv
hdl/pft_if.sv
hdl/pft_datapath.sv
hdl/pft_ctrl.sv
hdl/properties_file_tokenizer_unit.sv
dv/properties_file_tokenizer_unit_tb.sv
